/* rtl/lltbl_pkg.sv */
// shared types, widths and codes for the linked list table engine
package lltbl_pkg;

    localparam int CAPACITY     = 1024;
    localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W        = $clog2(CAPACITY + 1);
    localparam int KEY_W        = 32;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 10;
    localparam int COUNT_W      = 11;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 24;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ALLOC_RD,
        ST_INS_FREE,
        ST_INS_FRESH,
        ST_WALK,
        ST_DEL_LINK,
        ST_DEL_FREE,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    walk_init;
        logic    walk_step;
        logic    alloc_rd;
        logic    ins_free;
        logic    ins_fresh;
        logic    match_capture;
        logic    del_unlink;
        logic    del_free;
        logic    set_res;
        status_t res_code;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    op_valid;
        logic    free_avail;
        logic    fresh_avail;
        logic    walk_end;
        logic    walk_hit;
        logic    out_free;
    } dp_stat_t;

endpackage

/* rtl/lltbl_ctrl.sv */
// controller state machine sequencing insert, search and delete
module lltbl_ctrl import lltbl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!stat.op_valid) begin
                    state_next = ST_RESP;
                end else if (stat.op == OP_INSERT) begin
                    if (stat.free_avail) begin
                        state_next = ST_ALLOC_RD;
                    end else if (stat.fresh_avail) begin
                        state_next = ST_INS_FRESH;
                    end else begin
                        state_next = ST_RESP;
                    end
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_ALLOC_RD:  state_next = ST_INS_FREE;
            ST_INS_FREE:  state_next = ST_RESP;
            ST_INS_FRESH: state_next = ST_RESP;
            ST_WALK: begin
                if (stat.walk_end) begin
                    state_next = ST_RESP;
                end else if (stat.walk_hit) begin
                    state_next = (stat.op == OP_DELETE) ? ST_DEL_LINK : ST_RESP;
                end
            end
            ST_DEL_LINK: state_next = ST_DEL_FREE;
            ST_DEL_FREE: state_next = ST_RESP;
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.res_code = STAT_OK;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DISPATCH: begin
                if (!stat.op_valid) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = STAT_NOT_FOUND;
                end else if (stat.op == OP_INSERT) begin
                    if (stat.free_avail) begin
                        cmd.alloc_rd = 1'b1;
                    end else if (!stat.fresh_avail) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = STAT_FULL;
                    end
                end else begin
                    cmd.walk_init = 1'b1;
                end
            end
            ST_ALLOC_RD: cmd.alloc_rd = 1'b1;
            ST_INS_FREE: begin
                cmd.ins_free = 1'b1;
                cmd.set_res  = 1'b1;
            end
            ST_INS_FRESH: begin
                cmd.ins_fresh = 1'b1;
                cmd.set_res   = 1'b1;
            end
            ST_WALK: begin
                if (stat.walk_end) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = STAT_NOT_FOUND;
                end else if (stat.walk_hit) begin
                    cmd.match_capture = 1'b1;
                    cmd.set_res       = (stat.op != OP_DELETE);
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DEL_LINK: cmd.del_unlink = 1'b1;
            ST_DEL_FREE: begin
                cmd.del_free = 1'b1;
                cmd.set_res  = 1'b1;
            end
            ST_RESP: cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* rtl/lltbl_dp.sv */
// datapath: node stores, list pointers, counters and result register
module lltbl_dp import lltbl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [OPCODE_W-1:0]   in_opcode,
    input  logic [KEY_W-1:0]      in_key,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic [SLOT_FIELD_W-1:0] out_slot,
    output logic [COUNT_W-1:0]    out_count
);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    ptr_t             link_mem [CAPACITY];

    logic [KEY_W-1:0]    key_rd_reg;
    ptr_t                link_rd_reg;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    ptr_t                head_reg, head_next;
    ptr_t                free_reg, free_next;
    ptr_t                fresh_reg, fresh_next;
    logic [COUNT_W-1:0]  live_reg, live_next;
    ptr_t                cur_reg, cur_next;
    ptr_t                prev_reg, prev_next;
    ptr_t                walk_cnt_reg, walk_cnt_next;
    ptr_t                slot_reg, slot_next;
    ptr_t                lnk_reg, lnk_next;
    status_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    addr_t            rd_addr;
    logic             key_we;
    addr_t            key_waddr;
    logic             link_we;
    addr_t            link_waddr;
    ptr_t             link_wdata;
    ptr_t             alloc_slot;

    always_comb begin
        if (cmd.walk_init) begin
            rd_addr = head_reg[ADDR_W-1:0];
        end else if (cmd.alloc_rd) begin
            rd_addr = free_reg[ADDR_W-1:0];
        end else begin
            rd_addr = link_rd_reg[ADDR_W-1:0];
        end
    end

    assign alloc_slot = cmd.ins_free ? free_reg : fresh_reg;

    always_comb begin
        key_we     = cmd.ins_free || cmd.ins_fresh;
        key_waddr  = alloc_slot[ADDR_W-1:0];
        link_we    = 1'b0;
        link_waddr = alloc_slot[ADDR_W-1:0];
        link_wdata = head_reg;
        if (cmd.ins_free || cmd.ins_fresh) begin
            link_we = 1'b1;
        end else if (cmd.del_unlink && (prev_reg < NULL_PTR)) begin
            link_we    = 1'b1;
            link_waddr = prev_reg[ADDR_W-1:0];
            link_wdata = lnk_reg;
        end else if (cmd.del_free) begin
            link_we    = 1'b1;
            link_waddr = slot_reg[ADDR_W-1:0];
            link_wdata = free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

    always_comb begin
        stat.op          = opcode_t'(op_reg);
        stat.op_valid    = (op_reg == OP_INSERT) || (op_reg == OP_SEARCH)
                           || (op_reg == OP_DELETE);
        stat.free_avail  = (free_reg < NULL_PTR);
        stat.fresh_avail = (fresh_reg < NULL_PTR);
        stat.walk_end    = (cur_reg >= NULL_PTR) || (walk_cnt_reg == NULL_PTR);
        stat.walk_hit    = (key_rd_reg == key_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        live_next       = live_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        walk_cnt_next   = walk_cnt_reg;
        slot_next       = slot_reg;
        lnk_next        = lnk_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;

        if (cmd.load) begin
            op_next  = in_opcode;
            key_next = in_key;
        end
        if (cmd.walk_init) begin
            cur_next      = head_reg;
            prev_next     = NULL_PTR;
            walk_cnt_next = '0;
        end
        if (cmd.walk_step) begin
            prev_next     = cur_reg;
            cur_next      = link_rd_reg;
            walk_cnt_next = walk_cnt_reg + 1'b1;
        end
        if (cmd.ins_free || cmd.ins_fresh) begin
            slot_next = alloc_slot;
            head_next = alloc_slot;
            live_next = live_reg + 1'b1;
        end
        if (cmd.ins_free) begin
            free_next = link_rd_reg;
        end
        if (cmd.ins_fresh) begin
            fresh_next = fresh_reg + 1'b1;
        end
        if (cmd.match_capture) begin
            slot_next = cur_reg;
            lnk_next  = link_rd_reg;
        end
        if (cmd.del_unlink && (prev_reg >= NULL_PTR)) begin
            head_next = lnk_reg;
        end
        if (cmd.del_free) begin
            free_next = slot_reg;
            if (live_reg != '0) begin
                live_next = live_reg - 1'b1;
            end
        end
        if (cmd.set_res) begin
            res_next = cmd.res_code;
        end
        if (cmd.match_capture && cmd.set_res) begin
            slot_next = cur_reg;
        end

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = res_reg;
            out_slot_next   = (res_reg == STAT_OK) ? SLOT_FIELD_W'(slot_reg) : '0;
            out_count_next  = live_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= NULL_PTR;
            free_reg      <= NULL_PTR;
            fresh_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            free_reg      <= free_next;
            fresh_reg     <= fresh_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        walk_cnt_reg   <= walk_cnt_next;
        slot_reg       <= slot_next;
        lnk_reg        <= lnk_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_count  = out_count_reg;

endmodule

/* rtl/linked_list_table_engine.sv */
// top level of the linked list table engine
// Each transaction is one operation on a singly linked list of up to 1024 signed keys:
// insert at head, search for the newest match, or delete the newest match. Search and
// delete walk the chain one node per cycle through the registered read port of the node
// stores, visiting up to 1024 nodes. One operation is in progress at a time; the result
// sits in an output register, so the next transaction is taken while an earlier result
// still waits. No clearing pass is needed.
module linked_list_table_engine import lltbl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[31:0]
    input  logic [OPCODE_W-1:0] s_tuser,   // opcode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // slot[9:0], entry_count[20:10], zero fill
    output logic [STATUS_W-1:0] m_tuser    // status[1:0]
);

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic [SLOT_FIELD_W-1:0] out_slot;
    logic [COUNT_W-1:0]      out_count;

    lltbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lltbl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_count  (out_count)
    );

    assign m_tdata = M_DATA_W'({out_count, out_slot});

endmodule

/* rtl/lltbl_chk.sv */
// port checker for the linked list table engine and its bind
module lltbl_chk import lltbl_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // one operation in progress at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // failed operations report slot zero
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[SLOT_FIELD_W-1:0] == '0))
        else $error("nonzero slot on failed operation");

    // live count within capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SLOT_FIELD_W +: COUNT_W] <= COUNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    // store full only when the count is at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_FULL)
        |-> (m_tdata[SLOT_FIELD_W +: COUNT_W] == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

endmodule

bind linked_list_table_engine lltbl_chk u_lltbl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/lltbl_answer_checker.sv */
// answer checker for the linked list table engine: mirrors the list and compares every answer
module lltbl_answer_checker import lltbl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[31:0]
    input  logic [OPCODE_W-1:0] s_tuser,   // opcode[1:0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // slot[9:0], entry_count[20:10], zero fill
    input  logic [STATUS_W-1:0] m_tuser,   // status[1:0]
    output int                  mismatch_count,
    output int                  answers_due,
    output int                  answers_checked,
    output int                  full_answers
);

    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [COUNT_W-1:0]      count;
    } list_answer_t;

    logic [KEY_W-1:0] node_key  [CAPACITY];
    ptr_t             node_link [CAPACITY];
    ptr_t             head_ptr;
    ptr_t             free_ptr;
    int               fresh_used;
    int               live_entries;

    list_answer_t     answer_q [$];
    list_answer_t     want;
    list_answer_t     predicted;
    int               errs    = 0;
    int               checked = 0;
    int               fulls   = 0;

    // walk from the head; hit is CAPACITY when the key is absent
    task automatic find_node(input logic [KEY_W-1:0] key, output int hit, output int prev);
        int cur;
        int n;
        cur  = head_ptr;
        prev = CAPACITY;
        hit  = CAPACITY;
        for (n = 0; n < CAPACITY && cur < CAPACITY && hit == CAPACITY; n++) begin
            if (node_key[cur] == key) begin
                hit = cur;
            end else begin
                prev = cur;
                cur  = node_link[cur];
            end
        end
        if (hit == CAPACITY) begin
            prev = CAPACITY;
        end
    endtask

    task automatic apply_list_op(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                                 output list_answer_t ans);
        int      slot;
        int      prev;
        status_t st;
        slot = CAPACITY;
        st   = STAT_NOT_FOUND;
        case (opcode_t'(op))
            OP_INSERT: begin
                if (free_ptr < CAPACITY) begin
                    slot     = free_ptr;
                    free_ptr = node_link[slot];
                end else if (fresh_used < CAPACITY) begin
                    slot = fresh_used;
                    fresh_used++;
                end
                if (slot == CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    node_key[slot]  = key;
                    node_link[slot] = head_ptr;
                    head_ptr        = ptr_t'(slot);
                    live_entries++;
                    st = STAT_OK;
                end
            end
            OP_SEARCH: begin
                find_node(key, slot, prev);
                st = (slot < CAPACITY) ? STAT_OK : STAT_NOT_FOUND;
            end
            OP_DELETE: begin
                find_node(key, slot, prev);
                if (slot < CAPACITY) begin
                    if (prev >= CAPACITY) begin
                        head_ptr = node_link[slot];
                    end else begin
                        node_link[prev] = node_link[slot];
                    end
                    node_link[slot] = free_ptr;
                    free_ptr        = ptr_t'(slot);
                    if (live_entries > 0) begin
                        live_entries--;
                    end
                    st = STAT_OK;
                end
            end
            default: begin
                st = STAT_NOT_FOUND;
            end
        endcase
        ans.status = st;
        ans.slot   = (st == STAT_OK) ? SLOT_FIELD_W'(slot) : '0;
        ans.count  = COUNT_W'(live_entries);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr     = NULL_PTR;
            free_ptr     = NULL_PTR;
            fresh_used   = 0;
            live_entries = 0;
            answer_q.delete();
        end else begin
            // the answer to a transaction never leaves on the edge that accepts it
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    errs++;
                    $display("%0t unexpected answer: status %0d slot %0d count %0d", $time,
                             m_tuser, m_tdata[SLOT_FIELD_W-1:0],
                             m_tdata[SLOT_FIELD_W +: COUNT_W]);
                end else begin
                    want = answer_q.pop_front();
                    checked++;
                    if (want.status == STAT_FULL) begin
                        fulls++;
                    end
                    if (m_tuser !== want.status) begin
                        errs++;
                        $display("%0t status mismatch: expected %0d, actual %0d", $time,
                                 want.status, m_tuser);
                    end
                    if (m_tdata[SLOT_FIELD_W-1:0] !== want.slot) begin
                        errs++;
                        $display("%0t slot mismatch: expected %0d, actual %0d", $time,
                                 want.slot, m_tdata[SLOT_FIELD_W-1:0]);
                    end
                    if (m_tdata[SLOT_FIELD_W +: COUNT_W] !== want.count) begin
                        errs++;
                        $display("%0t entry count mismatch: expected %0d, actual %0d", $time,
                                 want.count, m_tdata[SLOT_FIELD_W +: COUNT_W]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_list_op(s_tuser, s_tdata, predicted);
                answer_q.push_back(predicted);
            end
        end
        mismatch_count  <= errs;
        answers_due     <= answer_q.size();
        answers_checked <= checked;
        full_answers    <= fulls;
    end

endmodule

/* tb/tb_linked_list_table_engine.sv */
// testbench top for the linked list table engine: stimulus, flow control and verdict
module tb_linked_list_table_engine;
    import lltbl_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 580;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OPCODE_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    logic calm = 1'b0;
    int   mismatch_count;
    int   answers_due;
    int   answers_checked;
    int   full_answers;
    int   ops_sent = 0;
    int   cycle_count = 0;
    int   i;

    linked_list_table_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lltbl_answer_checker u_answer_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .answers_due     (answers_due),
        .answers_checked (answers_checked),
        .full_answers    (full_answers)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    // small pool so that searches and deletes hit, with the key extremes in it
    function automatic logic [KEY_W-1:0] pool_key(input int idx);
        case (idx)
            0:       pool_key = 32'h8000_0000;
            1:       pool_key = 32'h7FFF_FFFF;
            2:       pool_key = 32'h0000_0000;
            3:       pool_key = 32'hFFFF_FFFF;
            default: pool_key = 32'(idx) * 32'h0F0F_1357;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        if ($urandom_range(0, 99) < 70) begin
            random_key = pool_key($urandom_range(0, 15));
        end else begin
            random_key = $urandom;
        end
    endfunction

    function automatic logic [OPCODE_W-1:0] random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            random_op = OP_INSERT;
        end else if (r < 70) begin
            random_op = OP_SEARCH;
        end else if (r < 97) begin
            random_op = OP_DELETE;
        end else begin
            random_op = OP_UNUSED;
        end
    endfunction

    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ops_sent++;
    endtask

    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_due != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, unused opcode, extremes, duplicates, head/middle/tail deletes, reuse
        send_op(OP_DELETE, 32'd5);
        send_op(OP_SEARCH, 32'd5);
        send_op(OP_UNUSED, 32'd0);
        send_op(OP_INSERT, 32'h8000_0000);
        send_op(OP_INSERT, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 32'h0000_0000);
        send_op(OP_INSERT, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h7FFF_FFFF);
        send_op(OP_SEARCH, 32'h7FFF_FFFF);
        send_op(OP_SEARCH, 32'h8000_0000);
        send_op(OP_SEARCH, 32'd12345);
        send_op(OP_DELETE, 32'h7FFF_FFFF);
        send_op(OP_SEARCH, 32'h7FFF_FFFF);
        send_op(OP_DELETE, 32'h8000_0000);
        send_op(OP_DELETE, 32'h0000_0000);
        send_op(OP_INSERT, 32'd42);
        send_op(OP_INSERT, 32'd43);
        send_op(OP_INSERT, 32'd44);
        send_op(OP_INSERT, 32'd45);
        send_op(OP_UNUSED, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 32'd45);
        send_op(OP_DELETE, 32'hFFFF_FFFF);
        send_op(OP_SEARCH, 32'd42);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 150 || i == 450) begin
                drain_answers();
            end
            if (i == 250) begin
                calm <= 1'b1;
            end
            if (i == 400) begin
                calm <= 1'b0;
            end
            send_op(random_op(), random_key());
        end

        drain_answers();
        repeat (64) @(posedge aclk);

        $display("run covered %0d operations: directed corner cases, random mixes over a key pool",
                 ops_sent);
        $display("with stalls and drain pauses; %0d answers checked, %0d of them store-full",
                 answers_checked, full_answers);
        if (mismatch_count == 0 && answers_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
